/* hw/rtl/pdst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pdst_pkg;

    // field widths
    localparam int unsigned GAIN_W  = 10;
    localparam int unsigned SPEED_W = 9;
    localparam int unsigned MAX_W   = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned CORR_W  = 12;
    localparam int unsigned MAG_W   = 8;
    localparam int unsigned MODE_W  = 2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ENABLE = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0]         GAIN_PROP_RST  = 10'd205;
    localparam logic [GAIN_W-1:0]         GAIN_DERIV_RST = 10'd256;
    localparam logic signed [SPEED_W-1:0] BASE_SPEED_RST = 9'sd50;
    localparam logic [MAX_W-1:0]          MAX_SPEED_RST  = 8'd255;

    // sensor patterns, left / centre / right
    localparam logic [2:0] PAT_NONE         = 3'b000;
    localparam logic [2:0] PAT_RIGHT        = 3'b001;
    localparam logic [2:0] PAT_CENTER       = 3'b010;
    localparam logic [2:0] PAT_CENTER_RIGHT = 3'b011;
    localparam logic [2:0] PAT_LEFT         = 3'b100;
    localparam logic [2:0] PAT_LEFT_CENTER  = 3'b110;

    // position codes
    localparam logic signed [POS_W-1:0] POS_FAR_LEFT   = -9'sd150;
    localparam logic signed [POS_W-1:0] POS_LEFT       = -9'sd100;
    localparam logic signed [POS_W-1:0] POS_HALF_LEFT  = -9'sd50;
    localparam logic signed [POS_W-1:0] POS_CENTER     = 9'sd0;
    localparam logic signed [POS_W-1:0] POS_HALF_RIGHT = 9'sd50;
    localparam logic signed [POS_W-1:0] POS_RIGHT      = 9'sd100;
    localparam logic signed [POS_W-1:0] POS_FAR_RIGHT  = 9'sd150;

    // correction limit
    localparam logic [CORR_W-2:0] CORR_LIMIT = 11'd2047;

    // drive modes
    localparam logic [MODE_W-1:0] MODE_FORWARD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPIN_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPIN_LEFT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOP       = 2'd3;

    typedef struct packed {
        logic left_near;
        logic center_near;
        logic right_near;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0]  position_code;
        logic signed [CORR_W-1:0] correction;
        logic [MAG_W-1:0]         left_speed_mag;
        logic [MAG_W-1:0]         right_speed_mag;
        logic [MODE_W-1:0]        drive_mode;
    } t_out;

endpackage

`default_nettype wire

/* hw/rtl/pd_steering_three_sensor_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-sensor PD steering unit. Each input transaction is one sample of three
// near/far bits; each one yields exactly one result transaction holding the
// position code, the saturated PD correction, both wheel speed magnitudes and
// the drive mode. The unit is a two-stage pipeline: the first stage decodes the
// position and forms both gain products and their sum, the second scales,
// saturates, clamps and picks the mode. It takes one sample per clock unless a
// full output register is not taken; each result passes the stage-one registers
// and then the output register. A full output register that is not taken holds
// the pipe, though one more sample can still be taken into the first stage.
// Configuration writes take effect at once and belong in idle periods only.
module pd_steering_three_sensor_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // sample channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  pdst_pkg::t_in                       i_in_data,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output pdst_pkg::t_out                      o_out_data,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [pdst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [pdst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned PPROD_W = pdst_pkg::GAIN_W + 1 + pdst_pkg::POS_W;
    localparam int unsigned DIFF_W  = pdst_pkg::POS_W + 1;
    localparam int unsigned DPROD_W = pdst_pkg::GAIN_W + 1 + DIFF_W;
    localparam int unsigned SUM_W   = DPROD_W + 1;
    localparam int unsigned QUO_W   = SUM_W - 8;
    localparam int unsigned WIDE_W  = pdst_pkg::CORR_W + 1;

    // configuration registers
    logic [pdst_pkg::GAIN_W-1:0]         r_gain_prop;
    logic [pdst_pkg::GAIN_W-1:0]         r_gain_deriv;
    logic signed [pdst_pkg::SPEED_W-1:0] r_base_speed;
    logic [pdst_pkg::MAX_W-1:0]          r_max_speed;
    logic                                r_drive_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop    <= pdst_pkg::GAIN_PROP_RST;
            r_gain_deriv   <= pdst_pkg::GAIN_DERIV_RST;
            r_base_speed   <= pdst_pkg::BASE_SPEED_RST;
            r_max_speed    <= pdst_pkg::MAX_SPEED_RST;
            r_drive_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdst_pkg::CFG_GAIN_PROP:    r_gain_prop    <= i_cfg_data;
                pdst_pkg::CFG_GAIN_DERIV:   r_gain_deriv   <= i_cfg_data;
                pdst_pkg::CFG_BASE_SPEED:   r_base_speed   <= i_cfg_data[pdst_pkg::SPEED_W-1:0];
                pdst_pkg::CFG_MAX_SPEED:    r_max_speed    <= i_cfg_data[pdst_pkg::MAX_W-1:0];
                pdst_pkg::CFG_DRIVE_ENABLE: r_drive_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic out_en;
    logic in_take;

    assign out_en     = !r_out_valid || i_out_ready;
    assign o_in_ready = out_en || !r_s1_valid;
    assign in_take    = i_in_valid && o_in_ready;

    // position decode from pattern and last side seen
    logic signed [pdst_pkg::POS_W-1:0] r_prev_pos;
    logic                              r_last_right;
    logic signed [pdst_pkg::POS_W-1:0] pos;
    logic                              n_last_right;

    always_comb begin
        n_last_right = r_last_right;
        unique case ({i_in_data.left_near, i_in_data.center_near, i_in_data.right_near})
            pdst_pkg::PAT_LEFT: begin
                pos          = pdst_pkg::POS_LEFT;
                n_last_right = 1'b0;
            end
            pdst_pkg::PAT_LEFT_CENTER: begin
                pos          = pdst_pkg::POS_HALF_LEFT;
                n_last_right = 1'b0;
            end
            pdst_pkg::PAT_CENTER_RIGHT: begin
                pos          = pdst_pkg::POS_HALF_RIGHT;
                n_last_right = 1'b1;
            end
            pdst_pkg::PAT_RIGHT: begin
                pos          = pdst_pkg::POS_RIGHT;
                n_last_right = 1'b1;
            end
            pdst_pkg::PAT_NONE: begin
                pos = r_last_right ? pdst_pkg::POS_FAR_RIGHT : pdst_pkg::POS_FAR_LEFT;
            end
            default: begin
                pos = pdst_pkg::POS_CENTER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos   <= '0;
            r_last_right <= 1'b0;
        end else if (in_take) begin
            r_prev_pos   <= pos;
            r_last_right <= n_last_right;
        end
    end

    // gain products and their sum
    logic signed [DIFF_W-1:0]  pos_diff;
    logic signed [PPROD_W-1:0] prop_prod;
    logic signed [DPROD_W-1:0] deriv_prod;
    logic signed [SUM_W-1:0]   n_sum;

    assign pos_diff   = {pos[pdst_pkg::POS_W-1], pos}
                      - {r_prev_pos[pdst_pkg::POS_W-1], r_prev_pos};
    assign prop_prod  = $signed({1'b0, r_gain_prop}) * pos;
    assign deriv_prod = $signed({1'b0, r_gain_deriv}) * pos_diff;
    assign n_sum      = {{(SUM_W-PPROD_W){prop_prod[PPROD_W-1]}}, prop_prod}
                      + {deriv_prod[DPROD_W-1], deriv_prod};

    // stage one registers
    logic signed [SUM_W-1:0]           r_s1_sum;
    logic signed [pdst_pkg::POS_W-1:0] r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_sum <= n_sum;
            r_s1_pos <= pos;
        end
    end

    // scale by 1/256 toward zero and saturate
    logic [SUM_W-1:0]                   sum_mag;
    logic [QUO_W-1:0]                   quo;
    logic [pdst_pkg::CORR_W-2:0]        corr_mag;
    logic signed [pdst_pkg::CORR_W-1:0] corr;

    assign sum_mag  = r_s1_sum[SUM_W-1] ? SUM_W'(-r_s1_sum) : SUM_W'(r_s1_sum);
    assign quo      = sum_mag[SUM_W-1:8];
    assign corr_mag = (quo > QUO_W'(pdst_pkg::CORR_LIMIT)) ? pdst_pkg::CORR_LIMIT
                                                           : quo[pdst_pkg::CORR_W-2:0];
    assign corr     = r_s1_sum[SUM_W-1] ? -$signed({1'b0, corr_mag})
                                        : $signed({1'b0, corr_mag});

    // wheel speeds with clamp, upper bound first
    logic signed [WIDE_W-1:0] base_w;
    logic signed [WIDE_W-1:0] corr_w;
    logic signed [WIDE_W-1:0] max_w;
    logic signed [WIDE_W-1:0] left_raw;
    logic signed [WIDE_W-1:0] right_raw;
    logic signed [WIDE_W-1:0] left_c;
    logic signed [WIDE_W-1:0] right_c;

    assign base_w    = {{(WIDE_W-pdst_pkg::SPEED_W){r_base_speed[pdst_pkg::SPEED_W-1]}},
                        r_base_speed};
    assign corr_w    = {corr[pdst_pkg::CORR_W-1], corr};
    assign max_w     = {{(WIDE_W-pdst_pkg::MAX_W){1'b0}}, r_max_speed};
    assign left_raw  = base_w + corr_w;
    assign right_raw = base_w - corr_w;

    always_comb begin
        if (left_raw > max_w) begin
            left_c = max_w;
        end else if (left_raw < -max_w) begin
            left_c = -max_w;
        end else begin
            left_c = left_raw;
        end
        if (right_raw > max_w) begin
            right_c = max_w;
        end else if (right_raw < -max_w) begin
            right_c = -max_w;
        end else begin
            right_c = right_raw;
        end
    end

    // magnitudes and drive mode
    logic signed [WIDE_W-1:0]     left_abs;
    logic signed [WIDE_W-1:0]     right_abs;
    logic [pdst_pkg::MODE_W-1:0]  mode;
    pdst_pkg::t_out               n_out;

    assign left_abs  = left_c[WIDE_W-1] ? -left_c : left_c;
    assign right_abs = right_c[WIDE_W-1] ? -right_c : right_c;

    always_comb begin
        if (left_c > 0 && right_c < 0) begin
            mode = pdst_pkg::MODE_SPIN_RIGHT;
        end else if (left_c < 0 && right_c > 0) begin
            mode = pdst_pkg::MODE_SPIN_LEFT;
        end else if (r_drive_enable) begin
            mode = pdst_pkg::MODE_FORWARD;
        end else begin
            mode = pdst_pkg::MODE_STOP;
        end
    end

    always_comb begin
        n_out.position_code   = r_s1_pos;
        n_out.correction      = corr;
        n_out.left_speed_mag  = left_abs[pdst_pkg::MAG_W-1:0];
        n_out.right_speed_mag = right_abs[pdst_pkg::MAG_W-1:0];
        n_out.drive_mode      = mode;
    end

    // output register
    pdst_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks on result contents
    a_pos_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.position_code == pdst_pkg::POS_FAR_LEFT
                      || r_out.position_code == pdst_pkg::POS_LEFT
                      || r_out.position_code == pdst_pkg::POS_HALF_LEFT
                      || r_out.position_code == pdst_pkg::POS_CENTER
                      || r_out.position_code == pdst_pkg::POS_HALF_RIGHT
                      || r_out.position_code == pdst_pkg::POS_RIGHT
                      || r_out.position_code == pdst_pkg::POS_FAR_RIGHT))
        else $error("position code outside legal set");

    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.left_speed_mag <= r_max_speed
                      && r_out.right_speed_mag <= r_max_speed))
        else $error("wheel speed above clamp limit");

    a_spin_right_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.drive_mode == pdst_pkg::MODE_SPIN_RIGHT)
            |-> (r_out.correction > 0))
        else $error("right spin without positive correction");

    a_spin_left_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.drive_mode == pdst_pkg::MODE_SPIN_LEFT)
            |-> (r_out.correction < 0))
        else $error("left spin without negative correction");

endmodule

`default_nettype wire
